/* rtl/fcm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the FAT cluster chain sector map.
// No dependencies; imported by fcm_byte_store, fat_cluster_chain_sector_map_core and tb.
package fcm_pkg;

   // Default size of the local FAT copy in bytes
   localparam int STORE_BYTES_DEFAULT = 8192;

   // Width for byte offsets computed from a cluster number (covers 3 * 65535 / 2 + 1)
   localparam int CALC_W = 18;

   // Field widths
   localparam int CLUSTER_W  = 16;
   localparam int SECTOR_W   = 16;
   localparam int LOG2_W     = 3;
   localparam int OFFSET_W   = 7;
   localparam int ADDR_W     = 32;
   localparam int INDEX_W    = 13;
   localparam int CSR_IDX_W  = 2;

   // Cluster classification constants
   localparam logic [CLUSTER_W-1:0] END16_MASK = 16'hFFF0;
   localparam logic [CLUSTER_W-1:0] END12_MIN  = 16'h0FF0;
   localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 16'd2;

   // Register reset values
   localparam logic             FAT_KIND_RESET   = 1'b1;
   localparam logic [LOG2_W-1:0] CLUSTER_LOG2_RESET = 3'd3;
   localparam logic [ADDR_W-1:0] DATA_START_RESET  = 32'd0;

   typedef enum logic [0:0] {
      OP_LOAD      = 1'b0,
      OP_TRANSLATE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FREE  = 2'd1,
      STATUS_END   = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAT_KIND     = 2'd0,
      CSR_CLUSTER_LOG2 = 2'd1,
      CSR_DATA_START   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_READ_LO,
      ST_READ_HI,
      ST_FINISH
   } state_type;

   // Classify a cluster value: free/reserved, end/bad, or usable
   function automatic status_type fcm_check(input logic [CLUSTER_W-1:0] c,
                                            input logic                 fat16);
      status_type st;
      st = STATUS_OK;
      if (c < FIRST_DATA_CLUSTER) begin
         st = STATUS_FREE;
      end else if (fat16) begin
         if ((c & END16_MASK) == END16_MASK) st = STATUS_END;
      end else begin
         if (c >= END12_MIN) st = STATUS_END;
      end
      return st;
   endfunction

   // Assemble the next cluster from the two entry bytes
   function automatic logic [CLUSTER_W-1:0] fcm_decode(input logic [7:0] lo,
                                                       input logic [7:0] hi,
                                                       input logic       odd,
                                                       input logic       fat16);
      logic [CLUSTER_W-1:0] v;
      if (fat16) begin
         v = {hi, lo};
      end else if (odd) begin
         v = {4'd0, hi, lo[7:4]};
      end else begin
         v = {4'd0, hi[3:0], lo};
      end
      return v;
   endfunction

endpackage

/* rtl/fcm_byte_store.sv */
`timescale 1ns / 1ps
// Byte-wide synchronous memory holding the local FAT copy.
// One write port, one read port with registered read data; uses fcm_pkg.
module fcm_byte_store
   import fcm_pkg::*;
#(
   parameter int DEPTH = STORE_BYTES_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] store_mem [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fat_cluster_chain_sector_map_core.sv */
`timescale 1ns / 1ps
// Top level of the FAT12/FAT16 cluster chain sector map.
// Depends on fcm_pkg and fcm_byte_store.
//
// A load word writes one byte of the local FAT copy and leaves the core idle.
// A translate word walks the cluster chain through the byte store, whose single
// read port supplies one byte per cycle: a hop is check and first read, second
// read and decode; hops = sector_in_file >> cluster_size_log2. The result sits
// in an output register, so the next word is taken while it waits; a walk that
// ends while the previous result is still untaken holds until that result
// leaves. The store needs no clearing after reset; the user must keep entries
// read only after loading, as the core itself does not enforce it.
module fat_cluster_chain_sector_map_core
   import fcm_pkg::*;
#(
   parameter int STORE_BYTES = STORE_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0]     csr_write_data,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [INDEX_W-1:0]    req_table_index,
   input  logic [7:0]            req_table_byte,
   input  logic [CLUSTER_W-1:0]  req_first_cluster,
   input  logic [SECTOR_W-1:0]   req_sector_in_file,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ADDR_W-1:0]     rsp_block_address,
   output logic [1:0]            rsp_status
);

   localparam int AW = $clog2(STORE_BYTES);
   localparam logic [CALC_W-1:0] STORE_LIMIT = CALC_W'(STORE_BYTES);

   // state and registers
   state_type             state_ff, state_in;
   logic                  fat_kind_ff;
   logic [LOG2_W-1:0]     log2_ff;
   logic [ADDR_W-1:0]     data_start_ff;
   logic [CLUSTER_W-1:0]  cluster_ff, cluster_in;
   logic [SECTOR_W-1:0]   hops_ff, hops_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [AW-1:0]         byte_addr_ff, byte_addr_in;
   logic [7:0]            lo_ff, lo_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   status_type            rsp_status_ff, rsp_status_in;

   // combinational helpers
   logic                  accept;
   logic                  out_free;
   status_type            chk;
   logic [CALC_W-1:0]     entry_base;
   logic                  beyond;
   logic                  walk_stop;
   logic [CALC_W-1:0]     load_idx;
   logic                  wr_en;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [7:0]            rd_data;
   logic [OFFSET_W-1:0]   offset_mask;
   logic [ADDR_W-1:0]     final_addr;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // entry byte offset of the current cluster
   assign chk = fcm_check(cluster_ff, fat_kind_ff);
   always_comb begin
      if (fat_kind_ff) begin
         entry_base = CALC_W'({cluster_ff, 1'b0});
      end else begin
         entry_base = CALC_W'(cluster_ff) + CALC_W'(cluster_ff >> 1);
      end
   end
   assign beyond    = (entry_base + CALC_W'(1)) >= STORE_LIMIT;
   assign walk_stop = (hops_ff == '0) || (chk != STATUS_OK) || beyond;

   // load writes go straight into the store
   assign load_idx = CALC_W'(req_table_index);
   assign wr_en    = accept && (req_op == OP_TRANSLATE ? 1'b0 : 1'b1) &&
                     (load_idx < STORE_LIMIT);

   assign offset_mask = OFFSET_W'((8'd1 << log2_ff) - 8'd1);
   assign final_addr  = data_start_ff +
                        (ADDR_W'(cluster_ff - FIRST_DATA_CLUSTER) << log2_ff) +
                        ADDR_W'(offset_ff);

   fcm_byte_store #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_idx[AW-1:0]),
      .wr_data (req_table_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_TRANSLATE)) state_in = ST_WALK;
         end
         ST_WALK: begin
            state_in = walk_stop ? ST_FINISH : ST_READ_LO;
         end
         ST_READ_LO: begin
            state_in = ST_READ_HI;
         end
         ST_READ_HI: begin
            state_in = ST_WALK;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      cluster_in    = cluster_ff;
      hops_in       = hops_ff;
      offset_in     = offset_ff;
      byte_addr_in  = byte_addr_ff;
      lo_in         = lo_ff;
      status_in     = status_ff;
      rd_en         = 1'b0;
      rd_addr       = entry_base[AW-1:0];
      rsp_valid_in  = (rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cluster_in = req_first_cluster;
               hops_in    = req_sector_in_file >> log2_ff;
               offset_in  = req_sector_in_file[OFFSET_W-1:0] & offset_mask;
            end
         end
         ST_WALK: begin
            // classify, then fetch the first entry byte
            if (hops_ff == '0 || chk != STATUS_OK) begin
               status_in = chk;
            end else if (beyond) begin
               status_in = STATUS_RANGE;
            end else begin
               status_in    = STATUS_OK;
               rd_en        = 1'b1;
               rd_addr      = entry_base[AW-1:0];
               byte_addr_in = entry_base[AW-1:0];
            end
         end
         ST_READ_LO: begin
            lo_in   = rd_data;
            rd_en   = 1'b1;
            rd_addr = byte_addr_ff + AW'(1);
         end
         ST_READ_HI: begin
            cluster_in = fcm_decode(lo_ff, rd_data, cluster_ff[0], fat_kind_ff);
            hops_in    = hops_ff - SECTOR_W'(1);
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = (status_ff == STATUS_OK) ? final_addr : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         fat_kind_ff   <= FAT_KIND_RESET;
         log2_ff       <= CLUSTER_LOG2_RESET;
         data_start_ff <= DATA_START_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FAT_KIND:     fat_kind_ff   <= csr_write_data[0];
               CSR_CLUSTER_LOG2: log2_ff       <= csr_write_data[LOG2_W-1:0];
               CSR_DATA_START:   data_start_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cluster_ff    <= cluster_in;
      hops_ff       <= hops_in;
      offset_ff     <= offset_in;
      byte_addr_ff  <= byte_addr_in;
      lo_ff         <= lo_in;
      status_ff     <= status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for fat_cluster_chain_sector_map_core: loads FAT bytes, walks
// FAT12/FAT16 cluster chains and checks every block address and status it returns.
// Depends on fcm_pkg and the core RTL only.
module tb;
   import fcm_pkg::*;

   localparam int STORE_BYTES = STORE_BYTES_DEFAULT;

   // one request word as offered on the req_ channel
   typedef struct {
      op_type               op;
      logic [INDEX_W-1:0]   index;
      logic [7:0]           data;
      logic [CLUSTER_W-1:0] first;
      logic [SECTOR_W-1:0]  sector;
   } fat_word_type;

   // outcome of one chain walk
   typedef struct {
      logic [ADDR_W-1:0] addr;
      status_type        status;
      bit                blind;
      int                hops;
   } walk_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FAT_KIND;
   logic [ADDR_W-1:0]    csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_op = OP_LOAD;
   logic [INDEX_W-1:0]   req_table_index = '0;
   logic [7:0]           req_table_byte = '0;
   logic [CLUSTER_W-1:0] req_first_cluster = '0;
   logic [SECTOR_W-1:0]  req_sector_in_file = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ADDR_W-1:0]    rsp_block_address;
   logic [1:0]           rsp_status;

   fat_cluster_chain_sector_map_core #(.STORE_BYTES(STORE_BYTES)) u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_table_index   (req_table_index),
      .req_table_byte    (req_table_byte),
      .req_first_cluster (req_first_cluster),
      .req_sector_in_file(req_sector_in_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_block_address (rsp_block_address),
      .rsp_status        (rsp_status)
   );

   // predictor copy of the FAT and the registers
   logic [7:0]        fat_mem [STORE_BYTES];
   logic              cfg_fat16 = FAT_KIND_RESET;
   logic [LOG2_W-1:0] cfg_log2 = CLUSTER_LOG2_RESET;
   logic [ADDR_W-1:0] cfg_base = DATA_START_RESET;

   // FAT contents as planned by the stimulus, ahead of the predictor
   logic [7:0] plan_mem [STORE_BYTES];
   bit         plan_set [STORE_BYTES];

   fat_word_type outgoing_words [$];
   walk_type     pending_blocks [$];
   fat_word_type cur_word;
   int        chain_heads [$];
   int        chain_lens [$];

   int     words_queued, words_taken, loads_taken, translates_taken, longest_walk;
   int     mismatches, results_seen;
   int     status_seen [4];
   int     send_idle_pct = 19, recv_idle_pct = 73;
   int     hold_at = 32'h7FFF_FFFF;
   int     hold_left;
   bit     hold_used;
   longint cycle_budget, cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // classify a cluster number under the current FAT kind
   function automatic status_type cluster_class(logic [CLUSTER_W-1:0] c);
      if (c < FIRST_DATA_CLUSTER) return STATUS_FREE;
      if (cfg_fat16) begin
         if ((c & END16_MASK) == END16_MASK) return STATUS_END;
      end else begin
         if (c >= END12_MIN) return STATUS_END;
      end
      return STATUS_OK;
   endfunction

   // walk the chain through either the predictor store or the planned one;
   // blind marks a planned walk that would touch a byte never loaded
   function automatic walk_type follow_chain(bit planned, logic [CLUSTER_W-1:0] first,
                                             logic [SECTOR_W-1:0] sector);
      walk_type             w;
      logic [CLUSTER_W-1:0] c;
      int                   hops_left;
      int                   b;
      logic [7:0]           lo, hi;
      w.addr = '0;
      w.status = STATUS_OK;
      w.blind = 1'b0;
      w.hops = 0;
      c = first;
      hops_left = int'(sector) >> cfg_log2;
      while (hops_left != 0 && w.status == STATUS_OK && !w.blind) begin
         w.status = cluster_class(c);
         if (w.status == STATUS_OK) begin
            b = cfg_fat16 ? 2 * int'(c) : (3 * int'(c)) >> 1;
            if (b + 1 >= STORE_BYTES) begin
               w.status = STATUS_RANGE;
            end else begin
               lo = planned ? plan_mem[b] : fat_mem[b];
               hi = planned ? plan_mem[b + 1] : fat_mem[b + 1];
               if (planned && !(plan_set[b] && plan_set[b + 1])) w.blind = 1'b1;
               if (cfg_fat16) c = {hi, lo};
               else if (c[0]) c = {4'd0, hi, lo[7:4]};
               else c = {4'd0, hi[3:0], lo};
               hops_left--;
               w.hops++;
            end
         end
      end
      if (w.status == STATUS_OK) w.status = cluster_class(c);
      if (w.status == STATUS_OK)
         w.addr = cfg_base + ((32'(c) - 32'd2) << cfg_log2)
                  + (32'(sector) & ((32'd1 << cfg_log2) - 32'd1));
      return w;
   endfunction

   // predictor: apply an accepted word, queue the block it should produce
   function automatic void record_word(fat_word_type w);
      walk_type r;
      if (w.op == OP_LOAD) begin
         if (int'(w.index) < STORE_BYTES) fat_mem[w.index] = w.data;
         loads_taken++;
      end else begin
         r = follow_chain(1'b0, w.first, w.sector);
         pending_blocks.push_back(r);
         translates_taken++;
         if (r.hops > longest_walk) longest_walk = r.hops;
      end
   endfunction

   function automatic void queue_word(fat_word_type w, int cost);
      outgoing_words.push_back(w);
      words_queued++;
      cycle_budget += cost;
   endfunction

   function automatic void queue_load(int idx, logic [7:0] val);
      fat_word_type w;
      w.op = OP_LOAD;
      w.index = INDEX_W'(idx);
      w.data = val;
      w.first = CLUSTER_W'($urandom);
      w.sector = SECTOR_W'($urandom);
      plan_mem[idx] = val;
      plan_set[idx] = 1'b1;
      queue_word(w, 4);
   endfunction

   // write one FAT entry; FAT12 keeps the neighbor's nibble of a shared byte
   function automatic void set_entry(int c, int v);
      int b;
      b = cfg_fat16 ? 2 * c : (3 * c) >> 1;
      if (cfg_fat16) begin
         queue_load(b, v[7:0]);
         queue_load(b + 1, v[15:8]);
      end else if (c % 2 != 0) begin
         queue_load(b, {v[3:0], plan_mem[b][3:0]});
         queue_load(b + 1, v[11:4]);
      end else begin
         queue_load(b, v[7:0]);
         queue_load(b + 1, {plan_mem[b + 1][7:4], v[11:8]});
      end
   endfunction

   // queue a translate only if its walk reads loaded bytes alone
   function automatic bit try_translate(int first, int sector);
      walk_type     w;
      fat_word_type x;
      w = follow_chain(1'b1, CLUSTER_W'(first), SECTOR_W'(sector));
      if (w.blind) return 1'b0;
      x.op = OP_TRANSLATE;
      x.index = INDEX_W'($urandom);
      x.data = 8'($urandom);
      x.first = CLUSTER_W'(first);
      x.sector = SECTOR_W'(sector);
      queue_word(x, 3 * w.hops + 8);
      return 1'b1;
   endfunction

   // translate whose start cluster stops the walk before any read
   function automatic void queue_stop_translate();
      int c;
      case ($urandom_range(2))
         0: c = int'($urandom_range(1));
         1: c = cfg_fat16 ? int'({12'hFFF, 4'($urandom)})
                          : int'($urandom_range(16'hFFFF, 16'h0FF0));
         default: c = cfg_fat16 ? int'($urandom_range(16'hFFEF, 4096))
                                : int'($urandom_range(16'hFFFF, 16'h0FF0));
      endcase
      void'(try_translate(c, int'($urandom)));
   endfunction

   function automatic void translate_on_chain(int k);
      int hops, sector;
      hops = $urandom_range(2 * chain_lens[k] + 1);
      sector = (hops << cfg_log2) | ($urandom_range(127) & ((1 << cfg_log2) - 1));
      if (!try_translate(chain_heads[k], sector)) queue_stop_translate();
   endfunction

   // lay down a fresh chain with random links and a random terminator
   function automatic void build_chain();
      int len, maxc, r, tail;
      int nodes [$];
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      maxc = cfg_fat16 ? 4095 : 4079;
      repeat (len) nodes.push_back($urandom_range(maxc, 2));
      for (int i = 0; i + 1 < len; i++) set_entry(nodes[i], nodes[i + 1]);
      r = $urandom_range(9);
      if (r == 6) tail = $urandom_range(1);
      else if (r == 7) tail = nodes[0];
      else if (r == 8 && cfg_fat16) tail = $urandom_range(16'hFFEF, 4096);
      else if (cfg_fat16) tail = 16'hFFF0 | $urandom_range(15);
      else tail = $urandom_range(12'hFFF, 12'hFF0);
      set_entry(nodes[len - 1], tail);
      chain_heads.push_back(nodes[0]);
      chain_lens.push_back(len);
      repeat (3) translate_on_chain(chain_heads.size() - 1);
   endfunction

   // self-linked cluster walked for the largest sector index
   function automatic void queue_long_walk();
      int c;
      c = $urandom_range(cfg_fat16 ? 4095 : 4079, 2);
      set_entry(c, c);
      if (!try_translate(c, 'hFFFF)) queue_stop_translate();
   endfunction

   function automatic void fill_phase(int n);
      int stop_at, r;
      stop_at = words_queued + n;
      while (words_queued < stop_at) begin
         r = $urandom_range(99);
         if (r < 12) begin
            queue_load(int'($urandom_range(STORE_BYTES - 1)), 8'($urandom));
         end else if (r < 22) begin
            if (!try_translate(int'($urandom), int'($urandom))) queue_stop_translate();
         end else if (r < 40 || chain_heads.size() == 0) begin
            build_chain();
         end else begin
            translate_on_chain($urandom_range(chain_heads.size() - 1));
         end
      end
   endfunction

   // register writes, only while the core is idle
   task automatic apply_settings(logic fat16, logic [LOG2_W-1:0] lg,
                                 logic [ADDR_W-1:0] base, int s_idle, int r_idle);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_FAT_KIND;
      csr_write_data <= 32'(fat16);
      @(posedge clock);
      csr_index <= CSR_CLUSTER_LOG2;
      csr_write_data <= 32'(lg);
      @(posedge clock);
      csr_index <= CSR_DATA_START;
      csr_write_data <= base;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_fat16 = fat16;
      cfg_log2 = lg;
      cfg_base = base;
      chain_heads.delete();
      chain_lens.delete();
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
   endtask

   // all words taken and all blocks back, then a wait for a trailing load
   task automatic wait_drain();
      while (words_taken != words_queued || pending_blocks.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            record_word(cur_word);
            words_taken++;
         end
         if (!req_valid || req_ready) begin
            if (outgoing_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_word = outgoing_words.pop_front();
               req_valid <= 1'b1;
               req_op <= cur_word.op;
               req_table_index <= cur_word.index;
               req_table_byte <= cur_word.data;
               req_first_cluster <= cur_word.first;
               req_sector_in_file <= cur_word.sector;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long response hold-off so the core backs up into req_ready
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_used && words_taken >= hold_at) begin
         hold_left <= 400;
         hold_used <= 1'b1;
      end
   end

   function automatic void report_mismatch(string field, logic [31:0] want,
                                           logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch in %s of result %0d: expected %h, got %h",
                  field, results_seen, want, got);
   endfunction

   // response monitor
   always @(posedge clock) begin
      walk_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            status_seen[rsp_status]++;
            if (pending_blocks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result with no translate outstanding: block %h status %0d",
                           rsp_block_address, rsp_status);
            end else begin
               e = pending_blocks.pop_front();
               if (rsp_block_address !== e.addr)
                  report_mismatch("block_address", e.addr, rsp_block_address);
               if (rsp_status !== e.status)
                  report_mismatch("status", 32'(e.status), 32'(rsp_status));
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog, limit grows with the queued work
   always @(posedge clock) begin
      cycles++;
      if (cycles > 4 * cycle_budget + 80 * longint'(words_queued) + 50000) begin
         $display("no progress, stopped after %0d cycles", cycles);
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < STORE_BYTES; i++) plan_mem[i] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed words under reset settings: FAT16, 8 sectors per cluster, base 0
      queue_load(0, 8'hF8);
      queue_load(STORE_BYTES - 1, 8'hFF);
      queue_load(1, 8'h00);
      set_entry(2, 3);
      set_entry(3, 'hFFFF);
      void'(try_translate(2, 0));
      void'(try_translate(2, 8));
      void'(try_translate(2, 15));
      void'(try_translate(2, 16));          // lands on end marker
      void'(try_translate(2, 24));          // chain ends early
      void'(try_translate(0, 5));           // free cluster
      void'(try_translate(1, 100));         // reserved cluster
      void'(try_translate('hFFF7, 'hFFFF));
      void'(try_translate(4096, 8));        // entry past end of store
      void'(try_translate('hFFEF, 0));      // highest usable cluster
      set_entry(4, 0);
      void'(try_translate(4, 8));           // walk ends on free entry
      set_entry(5, 'h2000);
      void'(try_translate(5, 16));          // out of store on second hop
      void'(try_translate(2, 'hFFFF));
      wait_drain();

      // random phases: sender idles lightly, receiver heavily
      apply_settings(1'b1, 3'd0, 32'hFFFF_FFFF, 19, 73);
      queue_long_walk();
      fill_phase(240);
      wait_drain();
      apply_settings(1'b0, 3'd7, $urandom, 19, 73);
      hold_at = words_taken + 30;
      fill_phase(240);
      wait_drain();

      // the other way round, with a full drain halfway through
      apply_settings(1'b0, 3'd0, 32'd0, 73, 19);
      fill_phase(120);
      wait_drain();
      fill_phase(120);
      queue_long_walk();
      wait_drain();
      apply_settings(1'b1, 3'd7, $urandom, 73, 19);
      fill_phase(240);
      wait_drain();

      // no idling on either side
      apply_settings(1'b1, 3'd2, $urandom, 0, 0);
      fill_phase(240);
      wait_drain();
      apply_settings(1'b0, 3'd3, 32'hFFFF_FFF0, 0, 0);
      fill_phase(240);
      wait_drain();

      $display("covered %0d FAT byte loads and %0d translates, longest walk %0d hops",
               loads_taken, translates_taken, longest_walk);
      $display("results: %0d ok, %0d free, %0d end of chain, %0d outside store",
               status_seen[STATUS_OK], status_seen[STATUS_FREE],
               status_seen[STATUS_END], status_seen[STATUS_RANGE]);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/fcm_pkg.sv
rtl/fcm_byte_store.sv
rtl/fat_cluster_chain_sector_map_core.sv
tb/sv/tb.sv
